FILE: design/gcol_pkg.sv
// Shared types and constants for the greedy graph coloring block.
package gcol_pkg;

  localparam int unsigned VID_W    = 5;
  localparam int unsigned COLOR_W  = 6;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STORE_D  = 32;

  typedef logic [VID_W-1:0]   vid_t;
  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [STORE_D-1:0] row_t;

  typedef enum logic [OP_W-1:0] {
    OP_EDGE  = 2'd0,
    OP_COLOR = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

endpackage

FILE: design/greedy_graph_coloring.sv
// Greedy vertex coloring engine over a 32-row adjacency bit matrix.
//
// Input channel (in_valid/in_ready) carries one transaction per command:
//   edge  : set both adjacency bits of vertex_a and vertex_b, no result
//   clear : empty adjacency, colors and running max, no result
//   color : give vertex_a the smallest color from 1 up that no neighbor holds
//           (a colored vertex keeps its color); one result transaction.
// Vertices at or beyond the graph size, and the unused op code, are dropped
// without a result.
// Result channel (out_valid/out_ready) carries vertex_id, vertex_color and
// max_color. An already colored vertex answers straight after its lookup; an
// uncolored one goes through the lookup, a neighbor color scan over every
// vertex (one color memory read per cycle) and a free color search, eight
// candidates per cycle, before it answers.
// The block takes one transaction at a time; in_ready is low during an edge
// update and until a color result is taken. A stalled receiver holds the
// result steady. Reset (rst_n low, synchronous) empties the graph through
// per-row valid bits, so the block is ready on the first cycle after reset.
module greedy_graph_coloring #(
  parameter int unsigned MAX_VERTICES = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [gcol_pkg::OP_W-1:0]     in_op,
  input  logic [gcol_pkg::VID_W-1:0]    in_vertex_a,
  input  logic [gcol_pkg::VID_W-1:0]    in_vertex_b,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [gcol_pkg::VID_W-1:0]    out_vertex_id,
  output logic [gcol_pkg::COLOR_W-1:0]  out_vertex_color,
  output logic [gcol_pkg::COLOR_W-1:0]  out_max_color
);

  // Graph size and highest color tried.
  localparam int unsigned VCNT = (MAX_VERTICES < gcol_pkg::STORE_D) ?
                                 MAX_VERTICES : gcol_pkg::STORE_D;
  localparam int unsigned CLIM = (MAX_VERTICES < 63) ? MAX_VERTICES : 63;
  localparam int unsigned SD   = gcol_pkg::STORE_D;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EDGEA = 7'b0000010,
    S_EDGEB = 7'b0000100,
    S_LOOK  = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_PICK  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Latched command.
  gcol_pkg::vid_t   a_r, b_r;
  gcol_pkg::color_t res_r, highest_r;

  // Adjacency memory and its row valid bits.
  gcol_pkg::row_t   adj_mem [SD];
  logic [SD-1:0]    adj_vld_r;
  gcol_pkg::row_t   adj_rd_r;
  logic             adj_rv_r;
  gcol_pkg::row_t   adj_q;
  gcol_pkg::vid_t   adj_ra, adj_wa;
  gcol_pkg::row_t   adj_wd;
  logic             adj_we;

  // Color memory and its entry valid bits.
  gcol_pkg::color_t col_mem [SD];
  logic [SD-1:0]    col_vld_r;
  gcol_pkg::color_t col_rd_r;
  logic             col_rv_r;
  gcol_pkg::color_t col_q;
  gcol_pkg::vid_t   col_ra;
  logic             col_we;

  // Scan and search datapath.
  gcol_pkg::row_t   nb_r;
  logic             pend_r;
  logic [5:0]       cnt_r;
  logic [63:0]      used_r;
  logic [2:0]       k_r;
  logic [7:0]       used_byte;
  logic             found;
  gcol_pkg::color_t pick;

  logic in_acc, a_in_range, b_in_range;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign in_acc    = in_valid && in_ready;

  assign out_vertex_id    = a_r;
  assign out_vertex_color = res_r;
  assign out_max_color    = highest_r;

  assign a_in_range = ({1'b0, in_vertex_a} < 6'(VCNT));
  assign b_in_range = ({1'b0, in_vertex_b} < 6'(VCNT));

  // Read addresses: the incoming vertex while idle, then the latched ones;
  // the color port walks every vertex during the scan.
  always_comb begin
    case (state_r)
      S_IDLE:  adj_ra = in_vertex_a;
      S_EDGEA: adj_ra = b_r;
      default: adj_ra = a_r;
    endcase
    case (state_r)
      S_IDLE:  col_ra = in_vertex_a;
      S_SCAN:  col_ra = cnt_r[gcol_pkg::VID_W-1:0];
      default: col_ra = a_r;
    endcase
  end

  // A row or entry never written since clear reads as zero.
  assign adj_q = adj_rv_r ? adj_rd_r : '0;
  assign col_q = col_rv_r ? col_rd_r : '0;

  // Edge update: OR the partner bit into row a, then into row b.
  assign adj_we = (state_r == S_EDGEA) || (state_r == S_EDGEB);
  assign adj_wa = (state_r == S_EDGEA) ? a_r : b_r;
  assign adj_wd = adj_q | (gcol_pkg::row_t'(1) << ((state_r == S_EDGEA) ? b_r : a_r));

  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[adj_wa] <= adj_wd;
    end
    adj_rd_r <= adj_mem[adj_ra];
    adj_rv_r <= adj_vld_r[adj_ra];
  end

  // Free color search: eight candidates per cycle, lowest wins.
  assign used_byte = used_r[{k_r, 3'b000} +: 8];

  always_comb begin
    gcol_pkg::color_t idx;
    found = 1'b0;
    pick  = '0;
    idx   = '0;
    for (int j = 7; j >= 0; j--) begin
      idx = {k_r, 3'(j)};
      if (!used_byte[j] && (idx != '0) && ({1'b0, idx} <= 7'(CLIM))) begin
        found = 1'b1;
        pick  = idx;
      end
    end
  end

  assign col_we = (state_r == S_PICK) && found;

  always_ff @(posedge clk) begin
    if (col_we) begin
      col_mem[a_r] <= pick;
    end
    col_rd_r <= col_mem[col_ra];
    col_rv_r <= col_vld_r[col_ra];
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if ((in_op == gcol_pkg::OP_EDGE) && a_in_range && b_in_range) begin
            state_nxt = S_EDGEA;
          end else if ((in_op == gcol_pkg::OP_COLOR) && a_in_range) begin
            state_nxt = S_LOOK;
          end
        end
      end
      S_EDGEA: state_nxt = S_EDGEB;
      S_EDGEB: state_nxt = S_IDLE;
      S_LOOK:  state_nxt = (col_q != '0) ? S_OUT : S_SCAN;
      S_SCAN:  state_nxt = (cnt_r == 6'(SD)) ? S_PICK : S_SCAN;
      S_PICK:  state_nxt = (found || (k_r == 3'd7)) ? S_OUT : S_PICK;
      S_OUT:   state_nxt = out_ready ? S_IDLE : S_OUT;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      adj_vld_r <= '0;
      col_vld_r <= '0;
      highest_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc && (in_op == gcol_pkg::OP_CLEAR)) begin
        adj_vld_r <= '0;
        col_vld_r <= '0;
        highest_r <= '0;
      end
      if (adj_we) begin
        adj_vld_r[adj_wa] <= 1'b1;
      end
      if (col_we) begin
        col_vld_r[a_r] <= 1'b1;
        if (pick > highest_r) begin
          highest_r <= pick;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          a_r <= in_vertex_a;
          b_r <= in_vertex_b;
        end
      end
      S_LOOK: begin
        // Hold the neighbor row; a colored vertex answers at once.
        nb_r   <= adj_q;
        res_r  <= col_q;
        cnt_r  <= '0;
        pend_r <= 1'b0;
        used_r <= '0;
      end
      S_SCAN: begin
        // Read one color per cycle; mark it in the next cycle if a neighbor.
        pend_r <= nb_r[0];
        nb_r   <= nb_r >> 1;
        cnt_r  <= cnt_r + 6'd1;
        if ((cnt_r != '0) && pend_r) begin
          used_r[col_q] <= 1'b1;
        end
        k_r <= '0;
      end
      S_PICK: begin
        if (found) begin
          res_r <= pick;
        end else if (k_r == 3'd7) begin
          res_r <= '0;
        end else begin
          k_r <= k_r + 3'd1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: design/gcol_chk.sv
// Port-level checker for the greedy graph coloring block, with its bind.
module gcol_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [gcol_pkg::OP_W-1:0]     in_op,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [gcol_pkg::VID_W-1:0]    out_vertex_id,
  input logic [gcol_pkg::COLOR_W-1:0]  out_vertex_color,
  input logic [gcol_pkg::COLOR_W-1:0]  out_max_color
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_vertex_id) &&
    $stable(out_vertex_color) && $stable(out_max_color))
    else $error("result changed while stalled");

  // No new transaction while a result waits.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while result pending");

  // The running maximum covers the color just reported.
  a_max_covers: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_vertex_color <= out_max_color)
    else $error("vertex color above running maximum");

  // Edge, clear and unused commands never produce a result.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op != gcol_pkg::OP_COLOR) |=> !out_valid)
    else $error("result after a non-color command");

endmodule

bind greedy_graph_coloring gcol_chk u_gcol_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_op            (in_op),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_vertex_id    (out_vertex_id),
  .out_vertex_color (out_vertex_color),
  .out_max_color    (out_max_color)
);

FILE: tb/tb_greedy_graph_coloring.sv
// Testbench for greedy_graph_coloring: directed and random command streams, each result checked.
`timescale 1ns / 100ps

module tb_greedy_graph_coloring;

  // Graph size used for the instance and the predictor.
  localparam int unsigned GRAPH_N     = 32;
  // Colors tried by the search: min(GRAPH_N, 63).
  localparam int unsigned COLOR_LIMIT = (GRAPH_N < 63) ? GRAPH_N : 63;
  // Cycles to let pass after the last result: worst color lookup plus a stall.
  localparam int unsigned DRAIN_CYCLES = 60;
  // Total command count (all phases) past which the random phase starts no new sequence.
  localparam int unsigned RANDOM_ITEMS = 1600;

  typedef struct {
    gcol_pkg::vid_t   id;
    gcol_pkg::color_t color;
    gcol_pkg::color_t maxc;
  } color_result_t;

  logic             clk;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  gcol_pkg::op_t    in_op = gcol_pkg::OP_NONE;
  gcol_pkg::vid_t   in_vertex_a = '0;
  gcol_pkg::vid_t   in_vertex_b = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  gcol_pkg::vid_t   out_vertex_id;
  gcol_pkg::color_t out_vertex_color;
  gcol_pkg::color_t out_max_color;

  // Predictor state: adjacency rows, vertex colors and running maximum.
  gcol_pkg::row_t   adj_rows [gcol_pkg::STORE_D];
  gcol_pkg::color_t vcolor   [gcol_pkg::STORE_D];
  gcol_pkg::color_t top_color;

  // Results still owed by the block, oldest first.
  color_result_t pending_colors[$];

  bit mismatch_seen = 1'b0;
  bit idle_on       = 1'b1;
  int unsigned cmds_sent = 0;
  int unsigned ready_hold = 0;

  greedy_graph_coloring #(
    .MAX_VERTICES(GRAPH_N)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_vertex_a     (in_vertex_a),
    .in_vertex_b     (in_vertex_b),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_vertex_id   (out_vertex_id),
    .out_vertex_color(out_vertex_color),
    .out_max_color   (out_max_color)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Empty the graph, the colors and the running maximum.
  function automatic void clear_graph();
    for (int i = 0; i < gcol_pkg::STORE_D; i++) begin
      adj_rows[i] = '0;
      vcolor[i]   = '0;
    end
    top_color = '0;
  endfunction

  // Apply one accepted command to the predictor; queue the result it owes.
  function automatic void apply_cmd(gcol_pkg::op_t op, gcol_pkg::vid_t a, gcol_pkg::vid_t b);
    logic [63:0]   taken;
    int unsigned   pick;
    color_result_t res;
    case (op)
      gcol_pkg::OP_EDGE: begin
        // Ignore edges that leave the graph; set both directions otherwise.
        if (a < GRAPH_N && b < GRAPH_N) begin
          adj_rows[a][b] = 1'b1;
          adj_rows[b][a] = 1'b1;
        end
      end
      gcol_pkg::OP_CLEAR: begin
        clear_graph();
      end
      gcol_pkg::OP_COLOR: begin
        if (a < GRAPH_N) begin
          // A colored vertex keeps its color; otherwise take the lowest free one.
          if (vcolor[a] == '0) begin
            taken = '0;
            for (int u = 0; u < gcol_pkg::STORE_D; u++) begin
              if (adj_rows[a][u]) taken[vcolor[u]] = 1'b1;
            end
            pick = 0;
            for (int c = 1; c <= COLOR_LIMIT; c++) begin
              if (pick == 0 && !taken[c]) pick = c;
            end
            vcolor[a] = gcol_pkg::color_t'(pick);
            if (gcol_pkg::color_t'(pick) > top_color) top_color = gcol_pkg::color_t'(pick);
          end
          res.id    = a;
          res.color = vcolor[a];
          res.maxc  = top_color;
          pending_colors.push_back(res);
        end
      end
      default: begin
        // Unused op: drop without a result.
      end
    endcase
  endfunction

  // Send one command transaction; valid stays up for a back-to-back successor.
  task automatic send_cmd(input gcol_pkg::op_t op, input gcol_pkg::vid_t a,
                          input gcol_pkg::vid_t b);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_op       <= op;
    in_vertex_a <= a;
    in_vertex_b <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_cmd(op, a, b);
    cmds_sent++;
  endtask

  // Send a command of random op and random vertices.
  task automatic send_noise();
    send_cmd(gcol_pkg::op_t'($urandom_range(0, 3)), gcol_pkg::vid_t'($urandom_range(0, 31)),
             gcol_pkg::vid_t'($urandom_range(0, 31)));
  endtask

  // Drop valid and wait until every owed result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_colors.size() != 0) @(posedge clk);
  endtask

  // Random permutation of all vertex numbers.
  task automatic shuffle_vertices(output gcol_pkg::vid_t perm[gcol_pkg::STORE_D]);
    gcol_pkg::vid_t tmp;
    int unsigned j;
    for (int i = 0; i < gcol_pkg::STORE_D; i++) perm[i] = gcol_pkg::vid_t'(i);
    for (int i = gcol_pkg::STORE_D - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      tmp     = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
  endtask

  // Drive out_ready in random bursts of stall and accept; no stalls when idling is off.
  always @(posedge clk) begin
    if (!rst_n || !idle_on) begin
      out_ready  <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      out_ready  <= ($urandom_range(0, 2) != 0);
      ready_hold <= $urandom_range(0, 6);
    end
  end

  // Compare each result transaction with the oldest owed result.
  always @(posedge clk) begin
    color_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_colors.size() == 0) begin
        $error("unexpected result: vertex_id %0d vertex_color %0d max_color %0d",
               out_vertex_id, out_vertex_color, out_max_color);
        mismatch_seen = 1'b1;
      end else begin
        want = pending_colors.pop_front();
        if (out_vertex_id !== want.id) begin
          $error("vertex_id: expected %0d, got %0d", want.id, out_vertex_id);
          mismatch_seen = 1'b1;
        end
        if (out_vertex_color !== want.color) begin
          $error("vertex_color: expected %0d, got %0d", want.color, out_vertex_color);
          mismatch_seen = 1'b1;
        end
        if (out_max_color !== want.maxc) begin
          $error("max_color: expected %0d, got %0d", want.maxc, out_max_color);
          mismatch_seen = 1'b1;
        end
      end
    end
  end

  // Hand-built cases: lone vertices, recolor, self-loop, unused op, chains, clear.
  task automatic test_directed();
    send_cmd(gcol_pkg::OP_COLOR, 5'd0, 5'd0);     // lone vertex gets color 1
    send_cmd(gcol_pkg::OP_COLOR, 5'd31, 5'd31);
    send_cmd(gcol_pkg::OP_COLOR, 5'd0, 5'd31);    // already colored: keep it
    send_cmd(gcol_pkg::OP_NONE, 5'd31, 5'd31);    // unused op: no result
    send_cmd(gcol_pkg::OP_NONE, 5'd0, 5'd0);
    send_cmd(gcol_pkg::OP_EDGE, 5'd5, 5'd5);      // self-loop must not block a color
    send_cmd(gcol_pkg::OP_COLOR, 5'd5, 5'd0);
    send_cmd(gcol_pkg::OP_EDGE, 5'd0, 5'd31);     // conflict after coloring: colors stay
    send_cmd(gcol_pkg::OP_COLOR, 5'd31, 5'd0);
    send_cmd(gcol_pkg::OP_EDGE, 5'd3, 5'd0);
    send_cmd(gcol_pkg::OP_EDGE, 5'd31, 5'd3);     // reversed direction
    send_cmd(gcol_pkg::OP_COLOR, 5'd3, 5'd31);
    send_cmd(gcol_pkg::OP_EDGE, 5'd7, 5'd3);
    send_cmd(gcol_pkg::OP_EDGE, 5'd0, 5'd7);
    send_cmd(gcol_pkg::OP_EDGE, 5'd7, 5'd0);      // duplicate edge
    send_cmd(gcol_pkg::OP_COLOR, 5'd7, 5'd7);
    send_cmd(gcol_pkg::OP_CLEAR, 5'd31, 5'd31);
    send_cmd(gcol_pkg::OP_COLOR, 5'd31, 5'd0);    // after clear: color 1, max 1
    send_cmd(gcol_pkg::OP_EDGE, 5'd30, 5'd31);
    send_cmd(gcol_pkg::OP_COLOR, 5'd30, 5'd0);
    send_cmd(gcol_pkg::OP_COLOR, 5'd0, 5'd0);
    send_cmd(gcol_pkg::OP_CLEAR, 5'd0, 5'd0);
    drain();
  endtask

  // Full graph: every vertex needs its own color, max climbs to the top color.
  task automatic test_complete_graph();
    gcol_pkg::vid_t perm[gcol_pkg::STORE_D];
    send_cmd(gcol_pkg::OP_CLEAR, 5'd0, 5'd0);
    for (int i = 0; i < GRAPH_N; i++) begin
      for (int j = i + 1; j < GRAPH_N; j++) begin
        if ($urandom_range(0, 1)) begin
          send_cmd(gcol_pkg::OP_EDGE, gcol_pkg::vid_t'(i), gcol_pkg::vid_t'(j));
        end else begin
          send_cmd(gcol_pkg::OP_EDGE, gcol_pkg::vid_t'(j), gcol_pkg::vid_t'(i));
        end
      end
    end
    shuffle_vertices(perm);
    for (int i = 0; i < GRAPH_N; i++) begin
      send_cmd(gcol_pkg::OP_COLOR, perm[i], gcol_pkg::vid_t'($urandom_range(0, 31)));
    end
    // Recolor a few: answers come from the held colors.
    repeat (4) send_cmd(gcol_pkg::OP_COLOR, gcol_pkg::vid_t'($urandom_range(0, 31)),
                        gcol_pkg::vid_t'($urandom_range(0, 31)));
    drain();
  endtask

  // One sequence: usually clear, build a random subgraph, color members of it in random order.
  task automatic color_random_graph();
    gcol_pkg::vid_t members[gcol_pkg::STORE_D];
    gcol_pkg::vid_t order[gcol_pkg::STORE_D];
    int unsigned k, n_edges, max_edges, x, y;
    shuffle_vertices(members);
    k         = $urandom_range(2, GRAPH_N);
    max_edges = ($urandom_range(0, 3) == 0) ? k * (k - 1) / 2 : 2 * k;
    n_edges   = $urandom_range(0, max_edges);
    // Now and then keep the old graph so colors carry across sequences.
    if ($urandom_range(0, 9) != 0) send_cmd(gcol_pkg::OP_CLEAR,
                                           gcol_pkg::vid_t'($urandom_range(0, 31)),
                                           gcol_pkg::vid_t'($urandom_range(0, 31)));
    repeat (n_edges) begin
      if ($urandom_range(0, 11) == 0) send_noise();
      x = $urandom_range(0, k - 1);
      y = $urandom_range(0, k - 1);
      send_cmd(gcol_pkg::OP_EDGE, members[x], members[y]);
    end
    shuffle_vertices(order);
    for (int i = 0; i < k; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        x = $urandom_range(0, k - 1);
        y = $urandom_range(0, k - 1);
        send_cmd(gcol_pkg::OP_EDGE, members[x], members[y]);
      end
      if ($urandom_range(0, 15) == 0) send_noise();
      // Color members picked through the second shuffle; the modulo may repeat or skip some.
      send_cmd(gcol_pkg::OP_COLOR, members[order[i] % k],
               gcol_pkg::vid_t'($urandom_range(0, 31)));
    end
    repeat ($urandom_range(1, 3)) begin
      x = $urandom_range(0, k - 1);
      send_cmd(gcol_pkg::OP_COLOR, members[x], gcol_pkg::vid_t'($urandom_range(0, 31)));
    end
  endtask

  // Random phase with idling on both sides.
  task automatic test_random_graphs();
    while (cmds_sent < RANDOM_ITEMS) color_random_graph();
    drain();
  endtask

  // Final stretch at full rate: no gaps, no stalls.
  task automatic test_full_rate();
    idle_on = 1'b0;
    repeat (4) color_random_graph();
    drain();
  endtask

  initial begin
    clear_graph();
    // Hold reset low from the start, then release it once.
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_complete_graph();
    test_random_graphs();
    test_full_rate();

    // Let trailing edge commands finish and catch any stray result.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!mismatch_seen && pending_colors.size() == 0) begin
      $display("tb_greedy_graph_coloring passed");
    end else begin
      $display("tb_greedy_graph_coloring failed");
    end
    $finish;
  end

  // Stop a hung run well past the slowest correct one.
  initial begin
    #20_000_000;
    $display("tb_greedy_graph_coloring failed");
    $finish;
  end

endmodule
